>>> hdl/pit_pkg.sv
// Shared types, codes and constants for the paired device ID table.
`timescale 1ns / 1ps

package pit_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam logic [4:0]  LimitReset        = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD_UPD = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_FIND    = 2'd2,
    OP_READ    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_RANGE     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] peer_id;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [15:0] patch;
  } record_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [3:0]  slot_index;
    logic [15:0] patch_in;
    logic [7:0]  minor_in;
    logic [7:0]  major_in;
    logic [15:0] peer_id;
  } in_data_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [4:0]  entry_count;
    logic [15:0] patch_out;
    logic [7:0]  minor_out;
    logic [7:0]  major_out;
    logic [15:0] peer_id_out;
    logic [3:0]  slot;
    logic        found;
  } out_data_t;

endpackage

>>> hdl/paired_id_table.sv
// Paired device ID table: record memory with a slot walk per request.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+--------------------------------------
//  s_axis    | in  | tvalid / tready      | tuser opcode, tdata id/version/index
//  m_axis    | out | tvalid / tready      | tuser status, tdata found/slot/record
//  cfg       | in  | cfg_we_i             | cfg_wdata_i = entries_in_use
//
// Each item walks limit = min(entries_in_use, TABLE_DEPTH) slots: one record read per
// cycle from the record memory, then a drain step, then the write back and the load
// of the result register, then a return to idle to take the next item; a new item
// is not taken before the last one has loaded its result.
// Reset clears all valid bits at once; records are not cleared.
// The next item is taken while a result waits; a stalled output holds the
// block in its final state until the result register frees up.
`timescale 1ns / 1ps

module paired_id_table #(
  parameter int unsigned TABLE_DEPTH = pit_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,       // entries_in_use
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,    // opcode
  input  logic [55:0] s_axis_tdata_i,    // peer_id, major_in, minor_in, patch_in, slot_index
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [2:0]  m_axis_tuser_o,    // status
  output logic [63:0] m_axis_tdata_o     // found, slot, peer_id_out, major_out,
                                         // minor_out, patch_out, entry_count
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int LimW = (CntW > 5) ? CntW : 5;
  localparam int SW   = (IdxW > 4) ? IdxW : 4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e              state_q;
  logic [4:0]          limit_cfg_q;
  logic [LimW-1:0]     lim;

  pit_pkg::opcode_e    op_q;
  pit_pkg::record_t    new_rec_q;
  logic [3:0]          idx_q;

  pit_pkg::record_t    mem_q [TABLE_DEPTH];
  pit_pkg::record_t    rdata_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  logic [CntW-1:0]     ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                p1_act_q;
  logic                p1_vbit_q;
  logic [IdxW-1:0]     p1_slot_q;
  logic                hit_q;
  logic [IdxW-1:0]     match_q;
  logic                empty_found_q;
  logic [IdxW-1:0]     empty_q;
  logic                sel_vbit_q;
  pit_pkg::record_t    rec_q;

  logic                m_tvalid_q;
  logic [63:0]         m_tdata_q;
  pit_pkg::status_e    m_tuser_q;

  logic                in_acc;
  logic                issue;
  logic [IdxW-1:0]     ptr_idx;
  logic                out_free;
  logic                finish;

  pit_pkg::status_e    res_st;
  pit_pkg::out_data_t  res_data;
  pit_pkg::record_t    res_rec;
  logic                wr_en;
  logic [IdxW-1:0]     wr_slot;
  logic [CntW-1:0]     cnt_out;
  logic [SW-1:0]       match_sw;
  logic [SW-1:0]       empty_sw;
  logic [SW-1:0]       p1_slot_sw;
  logic [SW-1:0]       idx_sw;
  logic [LimW-1:0]     cnt_ext;

  pit_pkg::in_data_t   in_data;

  assign in_data    = pit_pkg::in_data_t'(s_axis_tdata_i);
  assign lim        = (LimW'(limit_cfg_q) > LimW'(TABLE_DEPTH)) ? LimW'(TABLE_DEPTH)
                                                               : LimW'(limit_cfg_q);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign ptr_idx    = ptr_q[IdxW-1:0];
  assign issue      = (state_q == S_SCAN) && (LimW'(ptr_q) < lim);
  assign out_free   = !m_tvalid_q || m_axis_tready_i;
  assign finish     = (state_q == S_DONE) && out_free;

  assign match_sw   = SW'(match_q);
  assign empty_sw   = SW'(empty_q);
  assign p1_slot_sw = SW'(p1_slot_q);
  assign idx_sw     = SW'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_cfg_q <= pit_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (!issue) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // record memory: one read, one write port
  always_ff @(posedge clk_i) begin
    if (finish && wr_en) begin
      mem_q[wr_slot] <= new_rec_q;
    end
    rdata_q <= mem_q[ptr_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (finish && wr_en) begin
      valid_q[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q         <= '0;
      cnt_q         <= '0;
      p1_act_q      <= 1'b0;
      hit_q         <= 1'b0;
      empty_found_q <= 1'b0;
      sel_vbit_q    <= 1'b0;
    end else if (in_acc) begin
      ptr_q         <= '0;
      cnt_q         <= '0;
      p1_act_q      <= 1'b0;
      hit_q         <= 1'b0;
      empty_found_q <= 1'b0;
      sel_vbit_q    <= 1'b0;
    end else begin
      p1_act_q <= issue;
      if (issue) begin
        ptr_q <= ptr_q + CntW'(1);
        if (valid_q[ptr_idx]) begin
          cnt_q <= cnt_q + CntW'(1);
        end else if (!empty_found_q) begin
          empty_found_q <= 1'b1;
        end
      end
      if (p1_act_q) begin
        if (op_q == pit_pkg::OP_READ) begin
          if (p1_slot_sw == idx_sw) sel_vbit_q <= p1_vbit_q;
        end else if (p1_vbit_q && !hit_q && (rdata_q.peer_id == new_rec_q.peer_id)) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // payload of the walk
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q              <= pit_pkg::opcode_e'(s_axis_tuser_i);
      new_rec_q.peer_id <= in_data.peer_id;
      new_rec_q.major   <= in_data.major_in;
      new_rec_q.minor   <= in_data.minor_in;
      new_rec_q.patch   <= in_data.patch_in;
      idx_q             <= in_data.slot_index;
    end
    if (issue) begin
      p1_slot_q <= ptr_idx;
      p1_vbit_q <= valid_q[ptr_idx];
      if (!valid_q[ptr_idx] && !empty_found_q) empty_q <= ptr_idx;
    end
    if (p1_act_q) begin
      if (op_q == pit_pkg::OP_READ) begin
        if (p1_slot_sw == idx_sw) rec_q <= rdata_q;
      end else if (p1_vbit_q && !hit_q && (rdata_q.peer_id == new_rec_q.peer_id)) begin
        match_q <= p1_slot_q;
        rec_q   <= rdata_q;
      end
    end
  end

  always_comb begin
    res_st   = pit_pkg::ST_OK;
    res_data = '0;
    res_rec  = '0;
    wr_en    = 1'b0;
    wr_slot  = match_q;
    cnt_out  = cnt_q;
    unique case (op_q)
      pit_pkg::OP_ADD_UPD, pit_pkg::OP_UPDATE, pit_pkg::OP_FIND: begin
        if (hit_q) begin
          res_data.found = 1'b1;
          res_data.slot  = match_sw[3:0];
          res_rec        = (op_q == pit_pkg::OP_FIND) ? rec_q : new_rec_q;
          wr_en          = (op_q != pit_pkg::OP_FIND);
        end else if ((op_q == pit_pkg::OP_ADD_UPD) && empty_found_q) begin
          res_data.slot = empty_sw[3:0];
          res_rec       = new_rec_q;
          wr_en         = 1'b1;
          wr_slot       = empty_q;
          cnt_out       = cnt_q + CntW'(1);
        end else if (op_q == pit_pkg::OP_ADD_UPD) begin
          res_st = pit_pkg::ST_FULL;
        end else begin
          res_st = pit_pkg::ST_NOT_FOUND;
        end
      end
      pit_pkg::OP_READ: begin
        if (LimW'(idx_q) >= lim) begin
          res_st = pit_pkg::ST_RANGE;
        end else if (!sel_vbit_q) begin
          res_st        = pit_pkg::ST_EMPTY;
          res_data.slot = idx_q;
        end else begin
          res_data.slot = idx_q;
          res_rec       = rec_q;
        end
      end
      default: res_st = pit_pkg::ST_OK;
    endcase
    cnt_ext              = LimW'(cnt_out);
    res_data.peer_id_out = res_rec.peer_id;
    res_data.major_out   = res_rec.major;
    res_data.minor_out   = res_rec.minor;
    res_data.patch_out   = res_rec.patch;
    res_data.entry_count = cnt_ext[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (finish) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      m_tdata_q <= 64'(res_data);
      m_tuser_q <= res_st;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the paired device ID table: directed plan, then random traffic.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    pit_pkg::status_e status;
    logic             found;
    logic [3:0]       slot;
    pit_pkg::record_t rec;
    logic [4:0]       count;
  } table_result_t;

  typedef struct {
    bit                is_limit;
    logic [4:0]        limit_val;
    pit_pkg::opcode_e  op;
    pit_pkg::in_data_t payload;
    bit                typed;
    table_result_t     want;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [1:0]  s_user = '0;
  logic [55:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [2:0]  m_user;
  logic [63:0] m_data;

  logic             model_used [pit_pkg::TableDepthDefault];
  pit_pkg::record_t model_rec [pit_pkg::TableDepthDefault];
  logic [4:0]       model_limit;

  table_result_t table_replies_due[$];
  step_t         plan[$];
  logic [15:0]   id_pool[20];
  int            errors = 0;
  bit            hold_off_req = 1'b0;

  paired_id_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tuser_i  (s_user),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tuser_o  (m_user),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic table_result_t predict_table_access(pit_pkg::opcode_e op,
                                                         pit_pkg::in_data_t d);
    table_result_t r;
    int lim;
    int hit_slot;
    int free_slot;
    int s;
    int n;
    r.status = pit_pkg::ST_OK;
    r.found  = 1'b0;
    r.slot   = '0;
    r.rec    = '0;
    r.count  = '0;
    lim = (model_limit < pit_pkg::TableDepthDefault) ? model_limit
                                                      : pit_pkg::TableDepthDefault;
    hit_slot  = -1;
    free_slot = -1;
    for (int i = 0; i < lim; i++) begin
      if (model_used[i]) begin
        if (hit_slot < 0 && model_rec[i].peer_id == d.peer_id) hit_slot = i;
      end else if (free_slot < 0 && hit_slot < 0) begin
        free_slot = i;
      end
    end
    if (op == pit_pkg::OP_READ) begin
      if (d.slot_index >= lim) begin
        r.status = pit_pkg::ST_RANGE;
      end else if (!model_used[d.slot_index]) begin
        r.status = pit_pkg::ST_EMPTY;
        r.slot   = d.slot_index;
      end else begin
        r.slot = d.slot_index;
        r.rec  = model_rec[d.slot_index];
      end
    end else begin
      r.found = (hit_slot >= 0);
      s = (hit_slot >= 0) ? hit_slot : ((op == pit_pkg::OP_ADD_UPD) ? free_slot : -1);
      if (s < 0) begin
        r.status = (op == pit_pkg::OP_ADD_UPD) ? pit_pkg::ST_FULL : pit_pkg::ST_NOT_FOUND;
      end else begin
        if (op != pit_pkg::OP_FIND) begin
          model_used[s] = 1'b1;
          model_rec[s]  = {d.peer_id, d.major_in, d.minor_in, d.patch_in};
        end
        r.slot = s[3:0];
        r.rec  = model_rec[s];
      end
    end
    n = 0;
    for (int i = 0; i < lim; i++) if (model_used[i]) n++;
    r.count = n[4:0];
    return r;
  endfunction

  function automatic step_t op_row(pit_pkg::opcode_e op, logic [15:0] id, logic [7:0] ma,
                                   logic [7:0] mi, logic [15:0] pa, logic [3:0] idx);
    step_t s;
    s.is_limit  = 1'b0;
    s.limit_val = '0;
    s.op        = op;
    s.payload   = '{pad: '0, slot_index: idx, patch_in: pa, minor_in: mi,
                    major_in: ma, peer_id: id};
    s.typed        = 1'b0;
    s.want.status  = pit_pkg::ST_OK;
    s.want.found   = 1'b0;
    s.want.slot    = '0;
    s.want.rec     = '0;
    s.want.count   = '0;
    return s;
  endfunction

  function automatic step_t with_result(step_t s, pit_pkg::status_e st, logic fnd,
                                        logic [3:0] sl, pit_pkg::record_t rc,
                                        logic [4:0] cnt);
    s.typed       = 1'b1;
    s.want.status = st;
    s.want.found  = fnd;
    s.want.slot   = sl;
    s.want.rec    = rc;
    s.want.count  = cnt;
    return s;
  endfunction

  function automatic step_t limit_row(logic [4:0] v);
    step_t s;
    s = op_row(pit_pkg::OP_FIND, '0, '0, '0, '0, '0);
    s.is_limit  = 1'b1;
    s.limit_val = v;
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic drain_replies();
    s_valid <= 1'b0;
    while (table_replies_due.size() != 0) @(posedge clk_i);
    repeat (model_limit + 4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [4:0] v);
    drain_replies();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    model_limit = v;
  endtask

  task automatic send_item(pit_pkg::opcode_e op, pit_pkg::in_data_t d, bit typed,
                           table_result_t want, bit gapless);
    int gap;
    table_result_t r;
    gap = 0;
    if (!gapless) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 55) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= d;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    r = predict_table_access(op, d);
    table_replies_due.push_back(typed ? want : r);
  endtask

  // check each accepted reply against the oldest one due
  always @(posedge clk_i) begin
    table_result_t      w;
    pit_pkg::out_data_t got;
    if (rst_n && m_valid && m_ready) begin
      got = m_data;
      if (table_replies_due.size() == 0) begin
        report_mismatch("reply with none due", {29'd0, m_user}, '0);
      end else begin
        w = table_replies_due.pop_front();
        if (m_user !== w.status) report_mismatch("status", 32'(m_user), 32'(w.status));
        if (got.found !== w.found) report_mismatch("found", 32'(got.found), 32'(w.found));
        if (got.slot !== w.slot) report_mismatch("slot", 32'(got.slot), 32'(w.slot));
        if (got.peer_id_out !== w.rec.peer_id)
          report_mismatch("peer_id_out", 32'(got.peer_id_out), 32'(w.rec.peer_id));
        if (got.major_out !== w.rec.major)
          report_mismatch("major_out", 32'(got.major_out), 32'(w.rec.major));
        if (got.minor_out !== w.rec.minor)
          report_mismatch("minor_out", 32'(got.minor_out), 32'(w.rec.minor));
        if (got.patch_out !== w.rec.patch)
          report_mismatch("patch_out", 32'(got.patch_out), 32'(w.rec.patch));
        if (got.entry_count !== w.count)
          report_mismatch("entry_count", 32'(got.entry_count), 32'(w.count));
      end
    end
  end

  // receiver: random stalls, and one long hold-off on request
  initial begin
    int burst;
    int mode;
    int held;
    bit hold_done;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_done) begin
        m_ready <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(posedge clk_i);
          held++;
        end
        hold_done = 1'b1;
      end else begin
        burst = $urandom_range(1, 40);
        mode  = $urandom_range(0, 3);
        repeat (burst) begin
          case (mode)
            0:       m_ready <= 1'b1;
            3:       m_ready <= ($urandom_range(0, 19) != 0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
        if ($urandom_range(0, 29) == 0) begin
          m_ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    logic [4:0]        phase_limits[10];
    step_t             st;
    pit_pkg::in_data_t d;
    pit_pkg::opcode_e  op;
    bit                gapless;
    int                pick;

    phase_limits = '{5'd16, 5'd3, 5'd1, 5'd10, 5'd0, 5'd31, 5'd6, 5'd16, 5'd13, 5'd16};
    for (int i = 0; i < pit_pkg::TableDepthDefault; i++) begin
      model_used[i] = 1'b0;
      model_rec[i]  = '0;
    end
    model_limit = pit_pkg::LimitReset;
    for (int i = 0; i < 20; i++) id_pool[i] = 16'($urandom_range(0, 65535));
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;

    plan.push_back(with_result(op_row(pit_pkg::OP_READ, 16'h0, 8'h0, 8'h0, 16'h0, 4'd0),
                               pit_pkg::ST_EMPTY, 1'b0, 4'd0, '0, 5'd0));
    plan.push_back(with_result(op_row(pit_pkg::OP_FIND, 16'hFFFF, 8'h0, 8'h0, 16'h0, 4'd0),
                               pit_pkg::ST_NOT_FOUND, 1'b0, 4'd0, '0, 5'd0));
    plan.push_back(with_result(op_row(pit_pkg::OP_UPDATE, 16'h0, 8'h12, 8'h34, 16'h5678,
                                      4'd0),
                               pit_pkg::ST_NOT_FOUND, 1'b0, 4'd0, '0, 5'd0));
    plan.push_back(with_result(op_row(pit_pkg::OP_ADD_UPD, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                      4'd15),
                               pit_pkg::ST_OK, 1'b0, 4'd0,
                               {16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF}, 5'd1));
    plan.push_back(with_result(op_row(pit_pkg::OP_ADD_UPD, 16'h0, 8'h0, 8'h0, 16'h0, 4'd0),
                               pit_pkg::ST_OK, 1'b0, 4'd1, '0, 5'd2));
    plan.push_back(with_result(op_row(pit_pkg::OP_ADD_UPD, 16'hFFFF, 8'h01, 8'h02, 16'h0003,
                                      4'd0),
                               pit_pkg::ST_OK, 1'b1, 4'd0,
                               {16'hFFFF, 8'h01, 8'h02, 16'h0003}, 5'd2));
    plan.push_back(op_row(pit_pkg::OP_UPDATE, 16'h0, 8'hAA, 8'h55, 16'hA5A5, 4'd15));
    plan.push_back(op_row(pit_pkg::OP_FIND, 16'hFFFF, 8'h5A, 8'hC3, 16'h3C3C, 4'd9));
    plan.push_back(with_result(op_row(pit_pkg::OP_READ, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                      4'd15),
                               pit_pkg::ST_EMPTY, 1'b0, 4'd15, '0, 5'd2));
    plan.push_back(op_row(pit_pkg::OP_READ, 16'h0, 8'h0, 8'h0, 16'h0, 4'd1));
    plan.push_back(limit_row(5'd2));
    plan.push_back(with_result(op_row(pit_pkg::OP_ADD_UPD, 16'h1234, 8'h1, 8'h1, 16'h1,
                                      4'd0),
                               pit_pkg::ST_FULL, 1'b0, 4'd0, '0, 5'd2));
    plan.push_back(with_result(op_row(pit_pkg::OP_READ, 16'h0, 8'h0, 8'h0, 16'h0, 4'd2),
                               pit_pkg::ST_RANGE, 1'b0, 4'd0, '0, 5'd2));
    plan.push_back(op_row(pit_pkg::OP_UPDATE, 16'h0, 8'h11, 8'h22, 16'h3344, 4'd7));
    plan.push_back(limit_row(5'd1));
    plan.push_back(with_result(op_row(pit_pkg::OP_FIND, 16'h0, 8'h0, 8'h0, 16'h0, 4'd0),
                               pit_pkg::ST_NOT_FOUND, 1'b0, 4'd0, '0, 5'd1));
    plan.push_back(with_result(op_row(pit_pkg::OP_READ, 16'h0, 8'h0, 8'h0, 16'h0, 4'd1),
                               pit_pkg::ST_RANGE, 1'b0, 4'd0, '0, 5'd1));
    plan.push_back(limit_row(5'd0));
    plan.push_back(with_result(op_row(pit_pkg::OP_ADD_UPD, 16'h5555, 8'h5, 8'h5, 16'h5,
                                      4'd0),
                               pit_pkg::ST_FULL, 1'b0, 4'd0, '0, 5'd0));
    plan.push_back(with_result(op_row(pit_pkg::OP_FIND, 16'hFFFF, 8'h0, 8'h0, 16'h0, 4'd0),
                               pit_pkg::ST_NOT_FOUND, 1'b0, 4'd0, '0, 5'd0));
    plan.push_back(with_result(op_row(pit_pkg::OP_READ, 16'h0, 8'h0, 8'h0, 16'h0, 4'd0),
                               pit_pkg::ST_RANGE, 1'b0, 4'd0, '0, 5'd0));
    plan.push_back(limit_row(5'd31));
    plan.push_back(op_row(pit_pkg::OP_FIND, 16'h0, 8'h0, 8'h0, 16'h0, 4'd0));
    plan.push_back(op_row(pit_pkg::OP_ADD_UPD, 16'h8001, 8'h80, 8'h01, 16'h8000, 4'd8));
    plan.push_back(op_row(pit_pkg::OP_READ, 16'h0, 8'h0, 8'h0, 16'h0, 4'd2));
    plan.push_back(with_result(op_row(pit_pkg::OP_READ, 16'h0, 8'h0, 8'h0, 16'h0, 4'd15),
                               pit_pkg::ST_EMPTY, 1'b0, 4'd15, '0, 5'd3));
    plan.push_back(limit_row(5'd16));

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      st = plan[i];
      if (st.is_limit) write_limit(st.limit_val);
      else send_item(st.op, st.payload, st.typed, st.want, 1'b0);
    end

    for (int p = 0; p < 10; p++) begin
      write_limit(phase_limits[p]);
      if (p == 0) hold_off_req = 1'b1;
      gapless = ($urandom_range(0, 3) == 0);
      repeat (85) begin
        pick = $urandom_range(0, 99);
        op = (pick < 35) ? pit_pkg::OP_ADD_UPD : (pick < 55) ? pit_pkg::OP_UPDATE :
             (pick < 78) ? pit_pkg::OP_FIND : pit_pkg::OP_READ;
        d.pad        = '0;
        d.peer_id    = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 19)]
                                                   : 16'($urandom_range(0, 65535));
        d.major_in   = 8'($urandom_range(0, 255));
        d.minor_in   = 8'($urandom_range(0, 255));
        d.patch_in   = 16'($urandom_range(0, 65535));
        d.slot_index = 4'($urandom_range(0, 15));
        send_item(op, d, 1'b0, st.want, gapless);
      end
    end

    drain_replies();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
